/* rtl/core/tsq_pkg.sv */
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared constants and types of the temperature safety qualifier: sensor
// count, qualification window, class codes, register indexes and the
// update/result bundles passed between the datapath and the sensor bank.
// ----------------------------------------------------------------------------
package tsq_pkg;

    // Sizing
    localparam int WINDOW    = 4;
    localparam int SENSORS   = 6;
    localparam int LIMITS    = 6;
    localparam int SENSOR_W  = 3;
    localparam int TEMP_W    = 16;
    localparam int CLASS_W   = 2;
    localparam int RUN_W     = $clog2(WINDOW + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    // Sample classes / qualified states
    localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SAFE    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_UNSAFE  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_E       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CHAMB_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CHAMB_B = 3'd7;

    // Update request into the sensor bank
    typedef struct packed {
        logic                valid;
        logic [SENSOR_W-1:0] sensor;
        logic [CLASS_W-1:0]  cls;
        logic [TEMP_W-1:0]   temperature;
    } upd_t;

    // Per-request answer of the sensor bank
    typedef struct packed {
        logic [CLASS_W-1:0] state;
        logic               trip;
        logic [TEMP_W-1:0]  kept;
    } res_t;

endpackage

/* rtl/core/tsq_classifier.sv */
// ----------------------------------------------------------------------------
// tsq_classifier
// Classes one reading as invalid (outside the valid window), unsafe (above
// the sensor limit) or safe.
// ----------------------------------------------------------------------------
module tsq_classifier
(
    input  logic [tsq_pkg::TEMP_W-1:0]  temperature,
    input  logic [tsq_pkg::TEMP_W-1:0]  valid_min,
    input  logic [tsq_pkg::TEMP_W-1:0]  valid_max,
    input  logic [tsq_pkg::TEMP_W-1:0]  limit,
    output logic [tsq_pkg::CLASS_W-1:0] cls
);

    // Empty window (min > max) falls out as invalid for every reading
    always_comb
    begin
        if ((temperature < valid_min) || (temperature > valid_max))
        begin
            cls = tsq_pkg::CLASS_INVALID;
        end
        else if (temperature > limit)
        begin
            cls = tsq_pkg::CLASS_UNSAFE;
        end
        else
        begin
            cls = tsq_pkg::CLASS_SAFE;
        end
    end

endmodule

/* rtl/core/tsq_sensor_bank.sv */
// ----------------------------------------------------------------------------
// tsq_sensor_bank
// Per-sensor run tracking and qualification. Holds run class, run length,
// qualified state and kept temperature for every sensor, applies one update
// per cycle and answers with the updated state, kept value and trip flag.
// ----------------------------------------------------------------------------
module tsq_sensor_bank
(
    input  logic          clk,
    input  logic          rst_n,
    input  tsq_pkg::upd_t upd,
    output tsq_pkg::res_t res
);

    logic [tsq_pkg::CLASS_W-1:0] run_class_reg  [tsq_pkg::SENSORS];
    logic [tsq_pkg::CLASS_W-1:0] run_class_next [tsq_pkg::SENSORS];
    logic [tsq_pkg::RUN_W-1:0]   run_len_reg    [tsq_pkg::SENSORS];
    logic [tsq_pkg::RUN_W-1:0]   run_len_next   [tsq_pkg::SENSORS];
    logic [tsq_pkg::CLASS_W-1:0] qual_reg       [tsq_pkg::SENSORS];
    logic [tsq_pkg::CLASS_W-1:0] qual_next      [tsq_pkg::SENSORS];
    logic [tsq_pkg::TEMP_W-1:0]  kept_reg       [tsq_pkg::SENSORS];
    logic [tsq_pkg::TEMP_W-1:0]  kept_next      [tsq_pkg::SENSORS];

    // Next state per sensor; only the addressed sensor moves
    always_comb
    begin
        for (int i = 0; i < tsq_pkg::SENSORS; i++)
        begin
            run_class_next[i] = run_class_reg[i];
            run_len_next[i]   = run_len_reg[i];
            qual_next[i]      = qual_reg[i];
            kept_next[i]      = kept_reg[i];
            if (upd.valid && (upd.sensor == tsq_pkg::SENSOR_W'(i)))
            begin
                // extend the run (saturating) or start a new one
                if (upd.cls == run_class_reg[i])
                begin
                    if (run_len_reg[i] < tsq_pkg::RUN_W'(tsq_pkg::WINDOW))
                    begin
                        run_len_next[i] = tsq_pkg::RUN_W'(run_len_reg[i] + 1'b1);
                    end
                end
                else
                begin
                    run_class_next[i] = upd.cls;
                    run_len_next[i]   = tsq_pkg::RUN_W'(1);
                end
                // qualify only on a full window, safe otherwise
                if (run_len_next[i] >= tsq_pkg::RUN_W'(tsq_pkg::WINDOW))
                begin
                    qual_next[i] = run_class_next[i];
                end
                else
                begin
                    qual_next[i] = tsq_pkg::CLASS_SAFE;
                end
                if (qual_next[i] == tsq_pkg::CLASS_SAFE)
                begin
                    kept_next[i] = upd.temperature;
                end
            end
        end
    end

    // Answer: addressed sensor's new state, trip over all sensors.
    // An unknown sensor matches nothing and reads as invalid with zero.
    always_comb
    begin
        res.state = tsq_pkg::CLASS_INVALID;
        res.kept  = '0;
        res.trip  = 1'b0;
        for (int i = 0; i < tsq_pkg::SENSORS; i++)
        begin
            if (upd.sensor == tsq_pkg::SENSOR_W'(i))
            begin
                res.state = qual_next[i];
                res.kept  = kept_next[i];
            end
            if (qual_next[i] != tsq_pkg::CLASS_SAFE)
            begin
                res.trip = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsq_pkg::SENSORS; i++)
            begin
                run_class_reg[i] <= tsq_pkg::CLASS_INVALID;
                run_len_reg[i]   <= tsq_pkg::RUN_W'(tsq_pkg::WINDOW);
                qual_reg[i]      <= tsq_pkg::CLASS_INVALID;
                kept_reg[i]      <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < tsq_pkg::SENSORS; i++)
            begin
                run_class_reg[i] <= run_class_next[i];
                run_len_reg[i]   <= run_len_next[i];
                qual_reg[i]      <= qual_next[i];
                kept_reg[i]      <= kept_next[i];
            end
        end
    end

endmodule

/* rtl/core/temperature_safety_qualifier.sv */
// ----------------------------------------------------------------------------
// temperature_safety_qualifier
// Per-sensor temperature qualification with consecutive-sample filtering
// and a global trip flag.
// ----------------------------------------------------------------------------
// Accepts one sample request per clock and returns one result per request
// in order. The sample is captured in an input register, then classed
// and applied combinationally to the sensor state on its way into the
// output register. Throughput is one request per cycle, limited only by
// downstream backpressure; the output register lets a new request enter
// while a finished result waits. A sensor reports its reading's class only
// after WINDOW matching samples in a row and safe before that; trip is high
// while any sensor is not qualified safe. After reset all sensors start
// invalid with a full invalid run, so trip reads high until every sensor
// has taken a valid reading; the first valid reading breaks the invalid run
// and the sensor reads safe from then on until a new run fills a window.
// Sensor ids beyond the last sensor change nothing and return invalid with
// a zero temperature. Write configuration only while idle.
// ----------------------------------------------------------------------------
module temperature_safety_qualifier
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsq_pkg::CFG_W-1:0]          cfg_data,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tsq_pkg::TDATA_IN_W-1:0]     s_tdata,   // sensor_id[2:0], temperature[18:3]
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tsq_pkg::TDATA_OUT_W-1:0]    m_tdata    // sensor_echo[2:0], sensor_state[4:3],
                                                          // trip[5], last_valid_temperature[21:6]
);

    logic [tsq_pkg::TEMP_W-1:0]   valid_min_reg;
    logic [tsq_pkg::TEMP_W-1:0]   valid_max_reg;
    logic [tsq_pkg::TEMP_W-1:0]   limit_reg [tsq_pkg::LIMITS];

    logic                         in_valid_reg;
    logic [tsq_pkg::SENSOR_W-1:0] in_sensor_reg;
    logic [tsq_pkg::TEMP_W-1:0]   in_temp_reg;

    logic                         out_valid_reg;
    logic [tsq_pkg::SENSOR_W-1:0] out_sensor_reg;
    tsq_pkg::res_t                out_res_reg;

    logic                         advance;
    logic [tsq_pkg::TEMP_W-1:0]   limit_sel;
    logic [tsq_pkg::CLASS_W-1:0]  sample_cls;
    tsq_pkg::upd_t                upd;
    tsq_pkg::res_t                bank_res;

    // Handshake: stage moves when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_min_reg <= '0;
            valid_max_reg <= '1;
            for (int i = 0; i < tsq_pkg::LIMITS; i++)
            begin
                limit_reg[i] <= '1;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsq_pkg::REG_VALID_MIN:     valid_min_reg <= cfg_data;
                tsq_pkg::REG_VALID_MAX:     valid_max_reg <= cfg_data;
                tsq_pkg::REG_LIMIT_X:       limit_reg[0]  <= cfg_data;
                tsq_pkg::REG_LIMIT_Y:       limit_reg[1]  <= cfg_data;
                tsq_pkg::REG_LIMIT_Z:       limit_reg[2]  <= cfg_data;
                tsq_pkg::REG_LIMIT_E:       limit_reg[3]  <= cfg_data;
                tsq_pkg::REG_LIMIT_CHAMB_A: limit_reg[4]  <= cfg_data;
                tsq_pkg::REG_LIMIT_CHAMB_B: limit_reg[5]  <= cfg_data;
                default:                    valid_min_reg <= valid_min_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_sensor_reg <= s_tdata[tsq_pkg::SENSOR_W-1:0];
            in_temp_reg   <= s_tdata[tsq_pkg::SENSOR_W +: tsq_pkg::TEMP_W];
        end
    end

    // Limit of the addressed sensor
    always_comb
    begin
        limit_sel = '1;
        for (int i = 0; i < tsq_pkg::SENSORS; i++)
        begin
            if (in_sensor_reg == tsq_pkg::SENSOR_W'(i))
            begin
                limit_sel = limit_reg[i];
            end
        end
    end

    tsq_classifier u_classifier
    (
        .temperature (in_temp_reg),
        .valid_min   (valid_min_reg),
        .valid_max   (valid_max_reg),
        .limit       (limit_sel),
        .cls         (sample_cls)
    );

    always_comb
    begin
        upd.valid       = advance;
        upd.sensor      = in_sensor_reg;
        upd.cls         = sample_cls;
        upd.temperature = in_temp_reg;
    end

    tsq_sensor_bank u_sensor_bank
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .res   (bank_res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sensor_reg <= in_sensor_reg;
            out_res_reg    <= bank_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.kept, out_res_reg.trip,
                       out_res_reg.state, out_sensor_reg};

endmodule
